/* src/nidht_pkg.sv */
// ----------------------------------------------------------------------------
// nidht_pkg
// Shared types, codes and helpers for the node id hole tracker.
// ----------------------------------------------------------------------------
package nidht_pkg;

  localparam int unsigned MAX_IDS_DEF = 1024;

  localparam int unsigned MODE_W   = 2;
  localparam int unsigned ID_W     = 10;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned BOUND_W  = 11;

  // bitmap row geometry
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_RMW,
    S_SWP_RD,
    S_SWP_CHK
  } state_t;

  // bitmap port command
  typedef struct packed {
    logic rd;
    logic wr;
  } mem_cmd_t;

  // index of the highest set bit (0 when the word is empty)
  function automatic logic [BIT_W-1:0] top_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) begin
        r = BIT_W'(i);
      end
    end
    return r;
  endfunction

  // bits strictly below position b
  function automatic logic [WORD_W-1:0] below_mask(input logic [BIT_W-1:0] b);
    return (WORD_W'(1) << b) - WORD_W'(1);
  endfunction

endpackage

/* src/node_id_hole_tracker.sv */
// ----------------------------------------------------------------------------
// node_id_hole_tracker
// Node id allocator: presence bitmap plus bound register, hole tracking.
// ----------------------------------------------------------------------------
// Add/remove: row read in S_IDLE, written back in S_RMW; out-of-range id or
// unused mode answered in S_IDLE. Top-id removal with nothing lower in its
// row sweeps down the rows below. Clear: one row written per cycle, then done.
// Throughput: busy stays high through the bitmap access; the next beat can
// start in the cycle done is high. done is a one-cycle strobe, no backpressure.
// Reset (rst, sync): wipes the bitmap row by row with busy high.
// ----------------------------------------------------------------------------
module node_id_hole_tracker
  import nidht_pkg::*;
#(
  parameter int unsigned MAX_IDS = MAX_IDS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // command side: beat taken when start && !busy
  input  logic                start,
  output logic                busy,
  input  logic [MODE_W-1:0]   mode,
  input  logic [ID_W-1:0]     node_id,
  // result side: one beat per command, marked by done
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [BOUND_W-1:0]  bound,
  output logic                filled_hole
);

  localparam int unsigned ROWS  = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;

  // bitmap port between sequencer and RAM
  mem_cmd_t          mem_cmd;
  logic [ROW_W-1:0]  mem_addr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W-1:0] mem_rdata;

  // sequencer: decodes the command, does the read-modify-write on the
  // id's row, and runs the downward sweep when the top id goes away
  nidht_ctrl #(
    .MAX_IDS (MAX_IDS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .node_id     (node_id),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .bound       (bound),
    .filled_hole (filled_hole),
    .mem_cmd     (mem_cmd),
    .mem_addr    (mem_addr),
    .mem_wdata   (mem_wdata),
    .mem_rdata   (mem_rdata)
  );

  // presence bitmap, 32 ids per row
  nidht_map #(
    .MAX_IDS (MAX_IDS)
  ) u_map (
    .clk   (clk),
    .cmd   (mem_cmd),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

endmodule

/* src/nidht_map.sv */
// ----------------------------------------------------------------------------
// nidht_map
// Presence bitmap: single-port word RAM, registered read data.
// ----------------------------------------------------------------------------
module nidht_map
  import nidht_pkg::*;
#(
  parameter int unsigned MAX_IDS = MAX_IDS_DEF
) (
  input  logic                                       clk,
  input  mem_cmd_t                                   cmd,
  input  logic [((MAX_IDS+WORD_W-1)/WORD_W > 1 ?
                 $clog2((MAX_IDS+WORD_W-1)/WORD_W) : 1)-1:0] addr,
  input  logic [WORD_W-1:0]                          wdata,
  output logic [WORD_W-1:0]                          rdata
);

  localparam int unsigned ROWS = (MAX_IDS + WORD_W - 1) / WORD_W;

  logic [WORD_W-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata <= mem[addr];
    end
  end

endmodule

/* src/nidht_ctrl.sv */
// ----------------------------------------------------------------------------
// nidht_ctrl
// Sequencer: bitmap read-modify-write, trailing-hole sweep, clear sweep.
// ----------------------------------------------------------------------------
module nidht_ctrl
  import nidht_pkg::*;
#(
  parameter int unsigned MAX_IDS = MAX_IDS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [MODE_W-1:0]     mode,
  input  logic [ID_W-1:0]       node_id,
  output logic                  busy,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic [BOUND_W-1:0]    bound,
  output logic                  filled_hole,
  output mem_cmd_t              mem_cmd,
  output logic [((MAX_IDS+WORD_W-1)/WORD_W > 1 ?
                 $clog2((MAX_IDS+WORD_W-1)/WORD_W) : 1)-1:0] mem_addr,
  output logic [WORD_W-1:0]     mem_wdata,
  input  logic [WORD_W-1:0]     mem_rdata
);

  localparam int unsigned ROWS  = (MAX_IDS + WORD_W - 1) / WORD_W;
  localparam int unsigned ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned FID_W = ROW_W + BIT_W;
  localparam int unsigned BND_W = $clog2(MAX_IDS + 1);
  localparam int unsigned CMP_W = FID_W + BND_W;
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

  state_t              state, state_next;
  logic [ROW_W-1:0]    row, row_next;
  logic [BND_W-1:0]    bound_q, bound_next;
  status_t             status_q, status_next;
  logic                filled_q, filled_next;
  logic                done_q, done_next;
  logic                report, report_next;
  logic [MODE_W-1:0]   op_mode;
  logic [FID_W-1:0]    op_id;

  logic [FID_W-1:0]    id_in;
  logic                in_range;
  logic [ROW_W-1:0]    op_row;
  logic [BIT_W-1:0]    op_bit;
  logic                rbit;
  logic                at_or_above;
  logic                is_top;
  logic [WORD_W-1:0]   onehot;
  logic [WORD_W-1:0]   low;

  assign id_in       = FID_W'(node_id);
  assign in_range    = 32'(node_id) < 32'(MAX_IDS);
  assign op_row      = op_id[FID_W-1:BIT_W];
  assign op_bit      = op_id[BIT_W-1:0];
  assign rbit        = mem_rdata[op_bit];
  assign at_or_above = CMP_W'(op_id) >= CMP_W'(bound_q);
  assign is_top      = (CMP_W'(op_id) + CMP_W'(1)) == CMP_W'(bound_q);
  assign onehot      = WORD_W'(1) << op_bit;
  assign low         = mem_rdata & below_mask(op_bit);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;   // power-up wipe of the bitmap
      row      <= '0;
      bound_q  <= '0;
      status_q <= ST_OK;
      filled_q <= 1'b0;
      done_q   <= 1'b0;
      report   <= 1'b0;
    end else begin
      state    <= state_next;
      row      <= row_next;
      bound_q  <= bound_next;
      status_q <= status_next;
      filled_q <= filled_next;
      done_q   <= done_next;
      report   <= report_next;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      op_mode <= mode;
      op_id   <= id_in;
    end
  end

  always_comb begin
    state_next  = state;
    row_next    = row;
    bound_next  = bound_q;
    status_next = status_q;
    filled_next = filled_q;
    done_next   = 1'b0;
    report_next = report;
    mem_cmd     = '0;
    mem_addr    = row;
    mem_wdata   = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          case (mode)
            MODE_CLEAR: begin
              state_next  = S_CLEAR;
              row_next    = '0;
              report_next = 1'b1;
            end
            MODE_ADD, MODE_REMOVE: begin
              if (in_range) begin
                mem_cmd.rd = 1'b1;
                mem_addr   = id_in[FID_W-1:BIT_W];
                state_next = S_RMW;
              end else begin
                status_next = ST_RANGE;
                filled_next = 1'b0;
                done_next   = 1'b1;
              end
            end
            default: begin
              status_next = ST_OK;
              filled_next = 1'b0;
              done_next   = 1'b1;
            end
          endcase
        end
      end

      S_CLEAR: begin
        mem_cmd.wr = 1'b1;
        mem_addr   = row;
        mem_wdata  = '0;
        if (row == LAST_ROW) begin
          state_next  = S_IDLE;
          bound_next  = '0;
          status_next = ST_OK;
          filled_next = 1'b0;
          done_next   = report;
          report_next = 1'b0;
        end else begin
          row_next = row + ROW_W'(1);
        end
      end

      S_RMW: begin
        mem_addr    = op_row;
        status_next = ST_OK;
        filled_next = 1'b0;
        done_next   = 1'b1;
        state_next  = S_IDLE;
        if (op_mode == MODE_ADD) begin
          if (at_or_above) begin
            mem_cmd.wr = 1'b1;
            mem_wdata  = mem_rdata | onehot;
            bound_next = BND_W'(op_id) + BND_W'(1);
          end else if (rbit) begin
            status_next = ST_DUP;
          end else begin
            mem_cmd.wr  = 1'b1;
            mem_wdata   = mem_rdata | onehot;
            filled_next = 1'b1;
          end
        end else begin
          if (at_or_above || !rbit) begin
            status_next = ST_ABSENT;
          end else begin
            mem_cmd.wr = 1'b1;
            mem_wdata  = mem_rdata & ~onehot;
            if (is_top) begin
              if (|low) begin
                bound_next = BND_W'({op_row, top_bit(low)}) + BND_W'(1);
              end else if (op_row == '0) begin
                bound_next = '0;
              end else begin
                // top row ran dry below the id: walk down row by row
                done_next  = 1'b0;
                row_next   = op_row - ROW_W'(1);
                state_next = S_SWP_RD;
              end
            end
          end
        end
      end

      S_SWP_RD: begin
        mem_cmd.rd = 1'b1;
        mem_addr   = row;
        state_next = S_SWP_CHK;
      end

      S_SWP_CHK: begin
        if (|mem_rdata) begin
          bound_next  = BND_W'({row, top_bit(mem_rdata)}) + BND_W'(1);
          status_next = ST_OK;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else if (row == '0) begin
          bound_next  = '0;
          status_next = ST_OK;
          done_next   = 1'b1;
          state_next  = S_IDLE;
        end else begin
          // check this row while fetching the next one down
          row_next   = row - ROW_W'(1);
          mem_cmd.rd = 1'b1;
          mem_addr   = row - ROW_W'(1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy        = state != S_IDLE;
  assign done        = done_q;
  assign status      = status_q;
  assign bound       = BOUND_W'(bound_q);
  assign filled_hole = filled_q;

endmodule
